FILE: design/shb_pkg.sv
`timescale 1ns / 1ps

package shb_pkg;

	// SHA-1 working variables; also used for the chaining words
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	localparam int DIGEST_WORDS = 5;
	localparam int WIN_BITS     = 512;
	localparam int WORD_BITS    = 32;

	localparam work_t IV_WORK = '{
		a: 32'h67452301,
		b: 32'hEFCDAB89,
		c: 32'h98BADCFE,
		d: 32'h10325476,
		e: 32'hC3D2E1F0
	};

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	// round index where each function group starts
	localparam logic [6:0] RND_GRP1   = 7'd20;
	localparam logic [6:0] RND_GRP2   = 7'd40;
	localparam logic [6:0] RND_GRP3   = 7'd60;
	localparam logic [6:0] LAST_ROUND = 7'd79;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [2:0] OBUF_FULL = 3'd5;

endpackage

FILE: design/shb_msg_if.sv
`timescale 1ns / 1ps

interface shb_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte, output end_of_message,
		input ready);
	modport sink (input valid, input data_byte, input has_byte, input end_of_message,
		output ready);
endinterface

FILE: design/shb_digest_if.sv
`timescale 1ns / 1ps

interface shb_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        last_word;

	modport source (output valid, output digest_word, output last_word, input ready);
	modport sink (input valid, input digest_word, input last_word, output ready);
endinterface

FILE: design/shb_round.sv
`timescale 1ns / 1ps

// One SHA-1 round plus one step of the sliding 16-word schedule.
// win[15] is the current schedule word w[r], win[0] is w[r+15].
module shb_round import shb_pkg::*; (
	input  logic [6:0]        rnd,
	input  work_t             cur,
	input  logic [15:0][31:0] win,
	output work_t             nxt,
	output logic [31:0]       w_new
);

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] w_mix;

	always_comb begin
		if (rnd < RND_GRP1) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K_0;
		end else if (rnd < RND_GRP2) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_1;
		end else if (rnd < RND_GRP3) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K_2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_3;
		end
	end

	// w[r+16] = rotl1(w[r+13] ^ w[r+8] ^ w[r+2] ^ w[r])
	assign w_mix = win[2] ^ win[7] ^ win[13] ^ win[15];
	assign w_new = {w_mix[30:0], w_mix[31]};

	assign nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + win[15];
	assign nxt.b = cur.a;
	assign nxt.c = {cur.b[1:0], cur.b[31:2]};
	assign nxt.d = cur.c;
	assign nxt.e = cur.d;

endmodule

FILE: design/sha1_byte_stream_hasher.sv
`timescale 1ns / 1ps
// SHA-1 over a byte stream, one word (byte plus flags) per handshake.
// A byte that does not complete a block leaves the input ready for the next; a byte that completes
// one is followed by 80 rounds and a fold on the single round unit, with input stalled meanwhile.
// End of message: 0x80, zeros and the length shift in a byte at a time (the length going into an
// extra block if it spills); after one or two compressions the self-draining digest buffer loads.
// Reset (arst_n low, async): control and counts clear, chain loads the IV; data regs are not.
module sha1_byte_stream_hasher import shb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	shb_msg_if.sink       msg,
	shb_digest_if.source  digest
);

	typedef enum logic [2:0] {
		ST_IDLE,   // take message words
		ST_ROUND,  // 80 compression rounds through the shared round unit
		ST_FOLD,   // add working variables into the chaining words
		ST_PAD,    // shift in 0x80, zeros and the length, one byte a cycle
		ST_DONE    // hand the digest to the output buffer and restart
	} state_t;

	state_t state_q;

	// Block buffer: bytes shift in at the bottom, so after 64 bytes the first
	// byte sits at the top. During compression the same register acts as the
	// sliding 16-word schedule window and shifts by one word per round.
	logic [WIN_BITS-1:0] win_q;

	work_t       chain_q;
	work_t       work_q;
	logic [5:0]  fill_q;
	logic [63:0] bitlen_q;
	logic [6:0]  rnd_q;

	logic pad_q;    // padding still owed after the current compression
	logic mark_q;   // 0x80 marker already written
	logic ovf_q;    // marker landed inside the length field: length goes in next block
	logic final_q;  // current compression is the last one of the message

	// output buffer, head at index 0
	logic [31:0] obuf_q [DIGEST_WORDS];
	logic [2:0]  ocnt_q;

	work_t       rnd_nxt;
	logic [31:0] w_new;
	logic        in_fire;
	logic        out_fire;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;

	shb_round u_round (
		.rnd   (rnd_q),
		.cur   (work_q),
		.win   (win_q),
		.nxt   (rnd_nxt),
		.w_new (w_new)
	);

	assign msg.ready          = (state_q == ST_IDLE);
	assign in_fire            = msg.valid && msg.ready;

	assign digest.valid       = (ocnt_q != 3'd0);
	assign digest.digest_word = obuf_q[0];
	assign digest.last_word   = (ocnt_q == 3'd1);
	assign out_fire           = digest.valid && digest.ready;

	// length bytes, most significant first, at buffer positions 56..63
	assign len_byte = bitlen_q[{~fill_q[2:0], 3'b000} +: 8];

	always_comb begin
		if (!mark_q)
			pad_byte = PAD_MARK;
		else if (fill_q >= LEN_POS && !ovf_q)
			pad_byte = len_byte;
		else
			pad_byte = 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			chain_q  <= IV_WORK;
			fill_q   <= '0;
			bitlen_q <= '0;
			rnd_q    <= '0;
			pad_q    <= 1'b0;
			mark_q   <= 1'b0;
			ovf_q    <= 1'b0;
			final_q  <= 1'b0;
			ocnt_q   <= '0;
		end else begin
			if (out_fire) begin
				for (int i = 0; i < DIGEST_WORDS - 1; i++)
					obuf_q[i] <= obuf_q[i+1];
				ocnt_q <= ocnt_q - 3'd1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (msg.has_byte) begin
							win_q    <= {win_q[WIN_BITS-9:0], msg.data_byte};
							fill_q   <= fill_q + 6'd1;
							bitlen_q <= bitlen_q + 64'd8;
						end
						pad_q <= msg.end_of_message;
						// a full block is compressed before any padding
						if (msg.has_byte && fill_q == FILL_LAST) begin
							work_q  <= chain_q;
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (msg.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end

				ST_ROUND: begin
					work_q <= rnd_nxt;
					win_q  <= {win_q[WIN_BITS-WORD_BITS-1:0], w_new};
					rnd_q  <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND)
						state_q <= ST_FOLD;
				end

				ST_FOLD: begin
					chain_q.a <= chain_q.a + work_q.a;
					chain_q.b <= chain_q.b + work_q.b;
					chain_q.c <= chain_q.c + work_q.c;
					chain_q.d <= chain_q.d + work_q.d;
					chain_q.e <= chain_q.e + work_q.e;
					if (final_q)
						state_q <= ST_DONE;
					else if (pad_q)
						state_q <= ST_PAD;
					else
						state_q <= ST_IDLE;
				end

				ST_PAD: begin
					win_q  <= {win_q[WIN_BITS-9:0], pad_byte};
					fill_q <= fill_q + 6'd1;
					if (!mark_q)
						mark_q <= 1'b1;
					if (fill_q == FILL_LAST) begin
						// block full: the overflow block carries no length
						final_q <= mark_q && !ovf_q;
						ovf_q   <= 1'b0;
						work_q  <= chain_q;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end else if (!mark_q) begin
						ovf_q <= (fill_q >= LEN_POS);
					end
				end

				ST_DONE: begin
					// wait until the previous digest has fully drained
					if (ocnt_q == 3'd0) begin
						obuf_q[0] <= chain_q.a;
						obuf_q[1] <= chain_q.b;
						obuf_q[2] <= chain_q.c;
						obuf_q[3] <= chain_q.d;
						obuf_q[4] <= chain_q.e;
						ocnt_q    <= OBUF_FULL;
						chain_q   <= IV_WORK;
						fill_q    <= '0;
						bitlen_q  <= '0;
						pad_q     <= 1'b0;
						mark_q    <= 1'b0;
						final_q   <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: design/shb_checker.sv
`timescale 1ns / 1ps

module shb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_eom,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_word,
	input logic        out_last
);

	// no digest word shows while held in reset
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("digest valid during reset");

	// closing a message starts padding or a compression, so input stalls next cycle
	a_eom_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_eom |=> !in_ready)
		else $error("ready right after end of message");

	// digest words are buffered whole: no gap before the last word
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("gap inside digest");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("stalled digest word changed");

endmodule

bind sha1_byte_stream_hasher shb_checker u_shb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg.valid),
	.in_ready  (msg.ready),
	.in_eom    (msg.end_of_message),
	.out_valid (digest.valid),
	.out_ready (digest.ready),
	.out_word  (digest.digest_word),
	.out_last  (digest.last_word)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb import shb_pkg::*;;

	// one expected digest word as it should leave the block
	typedef struct {
		logic [31:0] word;
		logic        last;
	} digest_entry_t;

	// Tracks the SHA-1 state of the message in flight and holds the digest
	// words still owed by the block, oldest first.
	class sha1_scoreboard;
		work_t         chain;
		logic [7:0]    blk [64];
		int            fill;
		logic [63:0]   bit_len;
		digest_entry_t owed_digest [$];
		int            errors;

		function new();
			restart();
			errors = 0;
		endfunction

		function void restart();
			chain   = IV_WORK;
			fill    = 0;
			bit_len = '0;
		endfunction

		function logic [31:0] rol(logic [31:0] v, int s);
			return (v << s) | (v >> (32 - s));
		endfunction

		// 80-round compression of blk into the chaining words
		function void fold_block();
			logic [31:0] w [16];
			logic [31:0] a, b, c, d, e, f, k, t;
			for (int j = 0; j < 16; j++)
				w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
			a = chain.a;
			b = chain.b;
			c = chain.c;
			d = chain.d;
			e = chain.e;
			for (int r = 0; r < 80; r++) begin
				if (r >= 16)
					w[r%16] = rol(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
				if (r < RND_GRP1) begin
					f = (b & c) | (~b & d);
					k = K_0;
				end else if (r < RND_GRP2) begin
					f = b ^ c ^ d;
					k = K_1;
				end else if (r < RND_GRP3) begin
					f = (b & c) | (b & d) | (c & d);
					k = K_2;
				end else begin
					f = b ^ c ^ d;
					k = K_3;
				end
				t = rol(a, 5) + f + e + k + w[r%16];
				e = d;
				d = c;
				c = rol(b, 30);
				b = a;
				a = t;
			end
			chain.a += a;
			chain.b += b;
			chain.c += c;
			chain.d += d;
			chain.e += e;
		endfunction

		// accepted input word: absorb byte, and on end pad and queue the digest
		function void note_word(logic [7:0] data, logic has, logic eom);
			int pos;
			logic [31:0] h [5];
			if (has) begin
				blk[fill] = data;
				fill++;
				bit_len += 64'd8;
				if (fill == 64) begin
					fold_block();
					fill = 0;
				end
			end
			if (!eom)
				return;
			pos = fill;
			blk[pos] = PAD_MARK;
			pos++;
			if (pos > LEN_POS) begin
				for (int i = pos; i < 64; i++)
					blk[i] = 8'h00;
				fold_block();
				pos = 0;
			end
			for (int i = pos; i < LEN_POS; i++)
				blk[i] = 8'h00;
			for (int i = 0; i < 8; i++)
				blk[LEN_POS + i] = bit_len[63 - 8*i -: 8];
			fold_block();
			h = '{chain.a, chain.b, chain.c, chain.d, chain.e};
			for (int i = 0; i < DIGEST_WORDS; i++)
				owed_digest.push_back('{word: h[i], last: (i == DIGEST_WORDS - 1)});
			restart();
		endfunction

		function void check_digest_word(logic [31:0] word, logic last);
			digest_entry_t exp_e;
			if (owed_digest.size() == 0) begin
				$error("unexpected digest word %h (last_word %b)", word, last);
				errors++;
				return;
			end
			exp_e = owed_digest.pop_front();
			if (word !== exp_e.word) begin
				$error("digest_word: expected %h, got %h", exp_e.word, word);
				errors++;
			end
			if (last !== exp_e.last) begin
				$error("last_word: expected %b, got %b", exp_e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	shb_msg_if    msg_bus ();
	shb_digest_if digest_bus ();

	sha1_byte_stream_hasher DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_bus),
		.digest (digest_bus)
	);

	sha1_scoreboard sb = new();

	int tx_idle_pct;  // chance in 100 that the sender holds valid low at each draw
	int rx_idle_pct;  // chance in 100 that the receiver holds ready low at each draw
	int items_sent;   // accepted words carrying a byte or an end mark

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// receiver: new ready decision every falling edge
	initial begin
		digest_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			digest_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// digest side sampled at the rising edge, pre-update values
	always @(posedge clk) begin
		if (arst_n && digest_bus.valid && digest_bus.ready)
			sb.check_digest_word(digest_bus.digest_word, digest_bus.last_word);
	end

	// Drive one word; called and returns at a falling edge. Random hold-off
	// first, then valid stays up until the block takes the word.
	task automatic feed_word(input logic [7:0] data, input logic has, input logic eom);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			msg_bus.valid <= 1'b0;
			@(negedge clk);
		end
		msg_bus.valid          <= 1'b1;
		msg_bus.data_byte      <= data;
		msg_bus.has_byte       <= has;
		msg_bus.end_of_message <= eom;
		do
			@(posedge clk);
		while (!msg_bus.ready);
		sb.note_word(data, has, eom);
		if (has || eom)
			items_sent++;
		@(negedge clk);
	endtask

	// A whole message of random bytes. The last byte either rides along with
	// the end mark or the end comes as a word of its own; ignored words
	// (no byte, no end) are sprinkled in as noise.
	task automatic feed_message(input int n_bytes, input bit merge_end, input int noise_pct);
		for (int i = 0; i < n_bytes; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				feed_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			feed_word(8'($urandom_range(0, 255)), 1'b1, merge_end && (i == n_bytes - 1));
		end
		if (!merge_end || n_bytes == 0)
			feed_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	initial begin
		int n_bytes;
		int cycles;

		items_sent                 = 0;
		tx_idle_pct                = 32;
		rx_idle_pct                = 86;
		arst_n                     = 1'b0;
		msg_bus.valid              = 1'b0;
		msg_bus.data_byte          = 8'h00;
		msg_bus.has_byte           = 1'b0;
		msg_bus.end_of_message     = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed ---
		// empty message, end mark alone
		feed_word(8'h00, 1'b0, 1'b1);
		// ignored word, then empty message with junk on the data lines
		feed_word(8'hA5, 1'b0, 1'b0);
		feed_word(8'hFF, 1'b0, 1'b1);
		// "abc", last byte carried with the end mark
		feed_word(8'h61, 1'b1, 1'b0);
		feed_word(8'h62, 1'b1, 1'b0);
		feed_word(8'h63, 1'b1, 1'b1);
		// single-byte messages at both extremes, byte together with end
		feed_word(8'h00, 1'b1, 1'b1);
		feed_word(8'hFF, 1'b1, 1'b1);
		// bytes split by an ignored word, end on its own
		feed_word(8'hFF, 1'b1, 1'b0);
		feed_word(8'h5A, 1'b0, 1'b0);
		feed_word(8'h00, 1'b1, 1'b0);
		feed_word(8'h3C, 1'b0, 1'b1);

		// --- random messages ---
		// Length mix aims at block boundaries: the pad spilling into an
		// extra block (56..63 bytes left over), exact fills, multi-block.
		while (items_sent < 470) begin
			if (items_sent < 160) begin
				tx_idle_pct = 32;
				rx_idle_pct = 86;
			end else if (items_sent < 320) begin
				tx_idle_pct = 86;
				rx_idle_pct = 32;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: n_bytes = $urandom_range(0, 20);
				4, 5, 6:    n_bytes = $urandom_range(50, 70);
				7, 8:       n_bytes = $urandom_range(115, 130);
				default:    n_bytes = $urandom_range(0, 3);
			endcase
			// keep the last message from running far past the item budget
			if (n_bytes > 470 - items_sent)
				n_bytes = 470 - items_sent;
			feed_message(n_bytes, 1'($urandom_range(0, 1)), 8);
		end
		msg_bus.valid <= 1'b0;

		// drain: every owed digest word must show up
		while (sb.owed_digest.size() != 0)
			@(posedge clk);
		// then watch for strays a while longer (pad + two compressions)
		cycles = 0;
		while (cycles < 300) begin
			@(posedge clk);
			cycles++;
		end

		if (sb.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
